// ===== hdl/gfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared types, constants and helpers of the binary frame parser.
// ----------------------------------------------------------------------------
package gfp_pkg;

    // Width of the good-frame and checksum-error counters (8 to 64)
    localparam int CNT_W = 32;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 17;
    localparam int LEN_W   = 16;
    localparam int STAT_W  = 32;
    localparam int TDATA_W = 128;
    localparam int TUSER_W = 4;

    // Header bytes before the payload: two sync, class, id, two length
    localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(6);
    localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(4);

    // Configuration register indexes
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_LEN     = 2'd2;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h62;
    localparam logic [LEN_W-1:0]  MAX_LEN_RST     = 16'd512;

    typedef enum logic [2:0] {
        PH_SYNC1   = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_CLASS   = 3'd2,
        PH_ID      = 3'd3,
        PH_LEN     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_first;
        logic [BYTE_W-1:0] sync_second;
        logic [LEN_W-1:0]  max_len;
    } cfg_t;

    typedef struct packed {
        logic              accepted;
        logic [BYTE_W-1:0] byte_value;
        logic [POS_W-1:0]  byte_position;
        logic              frame_good;
        logic              checksum_error;
        logic              frame_dropped;
        logic [BYTE_W-1:0] msg_class;
        logic [BYTE_W-1:0] msg_id;
        logic [LEN_W-1:0]  payload_length;
        logic [STAT_W-1:0] good_frames;
        logic [STAT_W-1:0] checksum_errors;
    } res_t;

    // Low 32 bits of a counter, zero-extended when the counter is narrower
    function automatic logic [STAT_W-1:0] cnt_low(input logic [CNT_W-1:0] c);
        logic [63:0] w;
        w = 64'(c);
        return w[STAT_W-1:0];
    endfunction

endpackage

// ===== hdl/gfp_parse.sv =====
// ----------------------------------------------------------------------------
// gfp_parse
// Frame state, running Fletcher-8 sums and event counters; builds one
// result per accepted byte.
// ----------------------------------------------------------------------------
module gfp_parse
    import gfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              in_fire,
    input  logic [BYTE_W-1:0] in_byte,
    output res_t              res
);

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   position_reg, position_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [BYTE_W-1:0]  class_reg, class_next;
    logic [BYTE_W-1:0]  id_reg, id_next;
    logic [BYTE_W-1:0]  sum_a_reg, sum_a_next;
    logic [BYTE_W-1:0]  sum_b_reg, sum_b_next;
    logic [BYTE_W-1:0]  chk_low_reg, chk_low_next;
    logic [CNT_W-1:0]   good_cnt_reg, good_cnt_next;
    logic [CNT_W-1:0]   err_cnt_reg, err_cnt_next;

    logic               acc, good, bad, drop;
    logic [POS_W-1:0]   pos;
    logic [BYTE_W-1:0]  add_a;
    logic [LEN_W-1:0]   full_len;
    logic [POS_W-1:0]   chk_pos;

    // Running sums with this byte added
    assign add_a    = sum_a_reg + in_byte;
    assign full_len = {in_byte, len_reg[BYTE_W-1:0]};
    assign chk_pos  = HDR_BYTES + POS_W'(len_reg);

    // Next state of the frame finder
    always_comb begin
        phase_next    = phase_reg;
        position_next = position_reg;
        len_next      = len_reg;
        class_next    = class_reg;
        id_next       = id_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        chk_low_next  = chk_low_reg;
        good_cnt_next = good_cnt_reg;
        err_cnt_next  = err_cnt_reg;
        acc           = 1'b0;
        good          = 1'b0;
        bad           = 1'b0;
        drop          = 1'b0;
        pos           = position_reg;
        unique case (phase_reg)
            PH_SYNC1: begin
                if (in_byte == cfg.sync_first) begin
                    acc           = 1'b1;
                    pos           = '0;
                    phase_next    = PH_SYNC2;
                    position_next = POS_W'(1);
                end else begin
                    position_next = '0;
                end
            end
            PH_SYNC2: begin
                if (in_byte == cfg.sync_second) begin
                    acc           = 1'b1;
                    pos           = POS_W'(1);
                    phase_next    = PH_CLASS;
                    position_next = POS_W'(2);
                end else begin
                    drop          = 1'b1;
                    phase_next    = PH_SYNC1;
                    position_next = '0;
                end
            end
            PH_CLASS: begin
                // Restart the sums with the class byte
                acc           = 1'b1;
                pos           = POS_W'(2);
                class_next    = in_byte;
                sum_a_next    = in_byte;
                sum_b_next    = in_byte;
                phase_next    = PH_ID;
                position_next = POS_W'(3);
            end
            PH_ID: begin
                acc           = 1'b1;
                pos           = POS_W'(3);
                id_next       = in_byte;
                sum_a_next    = add_a;
                sum_b_next    = sum_b_reg + add_a;
                phase_next    = PH_LEN;
                position_next = POS_W'(4);
            end
            PH_LEN: begin
                acc        = 1'b1;
                sum_a_next = add_a;
                sum_b_next = sum_b_reg + add_a;
                if (position_reg == POS_LEN_LO) begin
                    pos           = POS_LEN_LO;
                    len_next      = LEN_W'(in_byte);
                    position_next = POS_W'(5);
                end else begin
                    pos           = POS_W'(5);
                    len_next      = full_len;
                    position_next = HDR_BYTES;
                    if (full_len > cfg.max_len) begin
                        // Oversize length: drop and wait for a new frame
                        drop          = 1'b1;
                        phase_next    = PH_SYNC1;
                        position_next = '0;
                    end else if (full_len == '0) begin
                        phase_next = PH_CHECK;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                acc           = 1'b1;
                sum_a_next    = add_a;
                sum_b_next    = sum_b_reg + add_a;
                if (position_reg >= chk_pos - POS_W'(1)) begin
                    phase_next = PH_CHECK;
                end
                position_next = position_reg + POS_W'(1);
            end
            PH_CHECK: begin
                acc = 1'b1;
                if (position_reg == chk_pos) begin
                    chk_low_next  = in_byte;
                    position_next = position_reg + POS_W'(1);
                end else begin
                    if (chk_low_reg == sum_a_reg && in_byte == sum_b_reg) begin
                        good          = 1'b1;
                        good_cnt_next = good_cnt_reg + CNT_W'(1);
                    end else begin
                        bad          = 1'b1;
                        err_cnt_next = err_cnt_reg + CNT_W'(1);
                    end
                    phase_next    = PH_SYNC1;
                    position_next = '0;
                end
            end
            default: begin
                phase_next    = PH_SYNC1;
                position_next = '0;
            end
        endcase
    end

    // Result for this byte, header fields and counters after the update
    always_comb begin
        res.accepted        = acc;
        res.byte_value      = acc ? in_byte : '0;
        res.byte_position   = acc ? pos : '0;
        res.frame_good      = good;
        res.checksum_error  = bad;
        res.frame_dropped   = drop;
        res.msg_class       = class_next;
        res.msg_id          = id_next;
        res.payload_length  = len_next;
        res.good_frames     = cnt_low(good_cnt_next);
        res.checksum_errors = cnt_low(err_cnt_next);
    end

    // Advance state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SYNC1;
            position_reg <= '0;
            len_reg      <= '0;
            class_reg    <= '0;
            id_reg       <= '0;
            sum_a_reg    <= '0;
            sum_b_reg    <= '0;
            chk_low_reg  <= '0;
            good_cnt_reg <= '0;
            err_cnt_reg  <= '0;
        end else if (in_fire) begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            len_reg      <= len_next;
            class_reg    <= class_next;
            id_reg       <= id_next;
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
            chk_low_reg  <= chk_low_next;
            good_cnt_reg <= good_cnt_next;
            err_cnt_reg  <= err_cnt_next;
        end
    end

endmodule

// ===== hdl/gfp_out_buf.sv =====
// ----------------------------------------------------------------------------
// gfp_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module gfp_out_buf
    import gfp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  res_t push_res,
    output logic has_room,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    logic [1:0] cnt_reg, cnt_next;
    res_t       head_reg, head_next;
    res_t       skid_reg, skid_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign has_room  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = head_reg;

    // Move the skid entry up on a pop, load new results where they belong
    always_comb begin
        head_next = head_reg;
        skid_next = skid_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
        if (pop) begin
            if (cnt_reg == 2'd2) begin
                head_next = skid_reg;
            end else if (push) begin
                head_next = push_res;
            end
        end else if (push && cnt_reg == 2'd0) begin
            head_next = push_res;
        end
        if (push && !pop && cnt_reg == 2'd1) begin
            skid_next = push_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== hdl/gnss_binary_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_core
// Finds sync/class/id/length/payload/checksum frames in a byte stream and
// reports every byte with its frame position and checksum outcome.
// ----------------------------------------------------------------------------
//  channel   | direction | ports               | item
//  ----------+-----------+---------------------+------------------------------
//  s_        | in        | tvalid tready tdata | one received byte
//  m_        | out       | tvalid tready tdata | one result per input byte
//            |           | tuser               |
//  cfg_      | in        | valid ready index   | register write, always ready
//            |           | data                |
//
//  One byte is taken per cycle while s_tready is high; each result is registered in the output buffer.
//  Rate is set by the parser, which updates its state on each accepted byte.
//  A two-entry output buffer keeps s_tready high while one result waits;
//  s_tready drops only when both entries are held by m_tready low.
//  Synchronous active-low reset returns to sync search, clears sums and
//  counters, and loads the default register values.
// ----------------------------------------------------------------------------
module gnss_binary_frame_parser_core
    import gfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] byte_in
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] byte_value, [24:8] byte_position, [32:25] msg_class,
    // [40:33] msg_id, [56:41] payload_length, [88:57] good_frames,
    // [120:89] checksum_errors, [127:121] zero
    output logic [TDATA_W-1:0] m_tdata,
    // [0] accepted, [1] frame_good, [2] checksum_error, [3] frame_dropped
    output logic [TUSER_W-1:0] m_tuser,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    cfg_t cfg_reg;
    res_t res;
    res_t out_res;
    logic room;
    logic in_fire;

    assign s_tready  = room;
    assign in_fire   = s_tvalid && room;
    assign cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first  <= SYNC_FIRST_RST;
            cfg_reg.sync_second <= SYNC_SECOND_RST;
            cfg_reg.max_len     <= MAX_LEN_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SYNC_FIRST:  cfg_reg.sync_first  <= cfg_data[7:0];
                REG_SYNC_SECOND: cfg_reg.sync_second <= cfg_data[7:0];
                REG_MAX_LEN:     cfg_reg.max_len     <= cfg_data;
                default: ;
            endcase
        end
    end

    gfp_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .in_fire (in_fire),
        .in_byte (s_tdata),
        .res     (res)
    );

    gfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_res  (res),
        .has_room  (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result item
    assign m_tdata = {7'd0,
                      out_res.checksum_errors,
                      out_res.good_frames,
                      out_res.payload_length,
                      out_res.msg_id,
                      out_res.msg_class,
                      out_res.byte_position,
                      out_res.byte_value};
    assign m_tuser = {out_res.frame_dropped,
                      out_res.checksum_error,
                      out_res.frame_good,
                      out_res.accepted};

endmodule

// ===== test/tb_gnss_binary_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_gnss_binary_frame_parser_core
// Self-checking bench for the binary frame parser. A clocked driver feeds
// bytes from a queue and a clocked monitor checks every result against a
// cycle-free frame tracker kept in step with the accepted bytes. Stimulus
// mixes directed frames, well-formed random frames, broken frames and noise
// under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_gnss_binary_frame_parser_core;
    import gfp_pkg::*;

    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int DRAIN_LIMIT    = 200_000;
    localparam int MAX_SHOWN      = 10;

    // Checksum fault to inject into a generated frame
    localparam int CK_OK    = 0;
    localparam int CK_BAD_A = 1;
    localparam int CK_BAD_B = 2;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = 8'h00;  // [7:0] byte_in
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    // [7:0] byte_value, [24:8] byte_position, [32:25] msg_class,
    // [40:33] msg_id, [56:41] payload_length, [88:57] good_frames,
    // [120:89] checksum_errors, [127:121] zero
    logic [TDATA_W-1:0] m_tdata;
    // [0] accepted, [1] frame_good, [2] checksum_error, [3] frame_dropped
    logic [TUSER_W-1:0] m_tuser;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = 2'd0;
    logic [15:0]        cfg_data  = 16'h0000;

    gnss_binary_frame_parser_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Pending bytes, expected results and bookkeeping
    logic [7:0] rx_bytes_q[$];
    res_t       exp_result_q[$];
    int         n_queued     = 0;
    int         n_accepted   = 0;
    int         n_results    = 0;
    int         n_errors     = 0;
    int         n_reg_writes = 0;
    int         n_rand_bytes = 0;
    int         n_drops      = 0;
    int         send_wait    = 0;
    int         recv_wait    = 0;
    bit         idle_en      = 1'b1;

    // Frame tracker state and its copy of the registers
    cfg_t             trk_cfg;
    phase_t           trk_phase;
    logic [POS_W-1:0] trk_pos;
    logic [LEN_W-1:0] trk_len;
    logic [7:0]       trk_class;
    logic [7:0]       trk_id;
    logic [7:0]       trk_sum_a;
    logic [7:0]       trk_sum_b;
    logic [7:0]       trk_check_lo;
    logic [CNT_W-1:0] trk_good_cnt;
    logic [CNT_W-1:0] trk_err_cnt;

    // Running checksum of the frame being generated
    logic [7:0] gen_a;
    logic [7:0] gen_b;

    function automatic void reset_frame_tracker();
        trk_cfg      = '{SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_LEN_RST};
        trk_phase    = PH_SYNC1;
        trk_pos      = '0;
        trk_len      = '0;
        trk_class    = '0;
        trk_id       = '0;
        trk_sum_a    = '0;
        trk_sum_b    = '0;
        trk_check_lo = '0;
        trk_good_cnt = '0;
        trk_err_cnt  = '0;
    endfunction

    // Advance the tracker by one byte and return the result it causes
    function automatic res_t track_byte(input logic [7:0] b);
        res_t             r;
        logic [POS_W-1:0] pos;
        logic [31:0]      last_pl;
        r   = '0;
        pos = trk_pos;
        case (trk_phase)
            PH_SYNC1: begin
                if (b == trk_cfg.sync_first) begin
                    r.accepted = 1'b1;
                    pos        = '0;
                    trk_phase  = PH_SYNC2;
                    trk_pos    = POS_W'(1);
                end else begin
                    trk_pos = '0;
                end
            end
            PH_SYNC2: begin
                if (b == trk_cfg.sync_second) begin
                    r.accepted = 1'b1;
                    pos        = POS_W'(1);
                    trk_phase  = PH_CLASS;
                    trk_pos    = POS_W'(2);
                end else begin
                    // discard the byte, do not retest it as a first sync
                    r.frame_dropped = 1'b1;
                    trk_phase       = PH_SYNC1;
                    trk_pos         = '0;
                end
            end
            PH_CLASS: begin
                r.accepted = 1'b1;
                pos        = POS_W'(2);
                trk_class  = b;
                trk_sum_a  = b;
                trk_sum_b  = b;
                trk_phase  = PH_ID;
                trk_pos    = POS_W'(3);
            end
            PH_ID: begin
                r.accepted = 1'b1;
                pos        = POS_W'(3);
                trk_id     = b;
                trk_sum_a  = trk_sum_a + b;
                trk_sum_b  = trk_sum_b + trk_sum_a;
                trk_phase  = PH_LEN;
                trk_pos    = POS_LEN_LO;
            end
            PH_LEN: begin
                r.accepted = 1'b1;
                trk_sum_a  = trk_sum_a + b;
                trk_sum_b  = trk_sum_b + trk_sum_a;
                if (trk_pos == POS_LEN_LO) begin
                    pos     = POS_LEN_LO;
                    trk_len = LEN_W'(b);
                    trk_pos = POS_LEN_LO + POS_W'(1);
                end else begin
                    pos     = POS_LEN_LO + POS_W'(1);
                    trk_len = {b, trk_len[7:0]};
                    trk_pos = HDR_BYTES;
                    if (trk_len > trk_cfg.max_len) begin
                        // oversize: report the byte, then drop the frame
                        r.frame_dropped = 1'b1;
                        trk_phase       = PH_SYNC1;
                        trk_pos         = '0;
                    end else if (trk_len == '0) begin
                        trk_phase = PH_CHECK;
                    end else begin
                        trk_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                r.accepted = 1'b1;
                trk_sum_a  = trk_sum_a + b;
                trk_sum_b  = trk_sum_b + trk_sum_a;
                last_pl    = 32'(HDR_BYTES) + 32'(trk_len) - 32'd1;
                if (32'(trk_pos) >= last_pl) begin
                    trk_phase = PH_CHECK;
                end
                trk_pos = trk_pos + POS_W'(1);
            end
            PH_CHECK: begin
                r.accepted = 1'b1;
                if (32'(trk_pos) == 32'(HDR_BYTES) + 32'(trk_len)) begin
                    trk_check_lo = b;
                    trk_pos      = trk_pos + POS_W'(1);
                end else begin
                    if (trk_check_lo == trk_sum_a && b == trk_sum_b) begin
                        r.frame_good = 1'b1;
                        trk_good_cnt = trk_good_cnt + CNT_W'(1);
                    end else begin
                        r.checksum_error = 1'b1;
                        trk_err_cnt      = trk_err_cnt + CNT_W'(1);
                    end
                    trk_phase = PH_SYNC1;
                    trk_pos   = '0;
                end
            end
            default: begin
                trk_phase = PH_SYNC1;
                trk_pos   = '0;
            end
        endcase
        if (r.accepted) begin
            r.byte_value    = b;
            r.byte_position = pos;
        end
        if (r.frame_dropped) begin
            n_drops++;
        end
        r.msg_class       = trk_class;
        r.msg_id          = trk_id;
        r.payload_length  = trk_len;
        r.good_frames     = STAT_W'(trk_good_cnt);
        r.checksum_errors = STAT_W'(trk_err_cnt);
        return r;
    endfunction

    function automatic int draw_wait();
        return idle_en ? int'($urandom_range(0, 8)) : 0;
    endfunction

    function automatic bit is_idle();
        return n_accepted == n_queued && exp_result_q.size() == 0;
    endfunction

    // Driver: predict on each accepted item, then present the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            reset_frame_tracker();
        end else begin
            if (s_tvalid && s_tready) begin
                exp_result_q.push_back(track_byte(s_tdata));
                n_accepted++;
                send_wait = draw_wait();
            end
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_tvalid <= 1'b0;
                end else if (rx_bytes_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_bytes_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN) begin
                $display("result %0d: %s expected %0h, got %0h",
                         n_results, fname, want, got);
            end
        end
    endtask

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (exp_result_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN) begin
                        $display("result %0d arrived with no byte outstanding", n_results);
                    end
                end else begin
                    want = exp_result_q.pop_front();
                    check_field("accepted", 64'(want.accepted), 64'(m_tuser[0]));
                    check_field("frame_good", 64'(want.frame_good), 64'(m_tuser[1]));
                    check_field("checksum_error", 64'(want.checksum_error),
                                64'(m_tuser[2]));
                    check_field("frame_dropped", 64'(want.frame_dropped),
                                64'(m_tuser[3]));
                    check_field("byte_value", 64'(want.byte_value), 64'(m_tdata[7:0]));
                    check_field("byte_position", 64'(want.byte_position),
                                64'(m_tdata[24:8]));
                    check_field("msg_class", 64'(want.msg_class), 64'(m_tdata[32:25]));
                    check_field("msg_id", 64'(want.msg_id), 64'(m_tdata[40:33]));
                    check_field("payload_length", 64'(want.payload_length),
                                64'(m_tdata[56:41]));
                    check_field("good_frames", 64'(want.good_frames),
                                64'(m_tdata[88:57]));
                    check_field("checksum_errors", 64'(want.checksum_errors),
                                64'(m_tdata[120:89]));
                    check_field("tdata padding", '0, 64'(m_tdata[TDATA_W-1:121]));
                end
                n_results++;
                recv_wait = draw_wait();
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_bytes_q.push_back(b);
        n_queued++;
    endtask

    task automatic push_summed(input logic [7:0] b);
        gen_a = gen_a + b;
        gen_b = gen_b + gen_a;
        push_byte(b);
    endtask

    task automatic start_body(input logic [7:0] cls, input logic [7:0] id);
        gen_a = '0;
        gen_b = '0;
        push_summed(cls);
        push_summed(id);
    endtask

    task automatic open_frame(input logic [7:0] cls, input logic [7:0] id);
        push_byte(trk_cfg.sync_first);
        push_byte(trk_cfg.sync_second);
        start_body(cls, id);
    endtask

    task automatic close_frame(input int fault);
        logic [7:0] ca;
        logic [7:0] cb;
        ca = gen_a;
        cb = gen_b;
        if (fault == CK_BAD_A) begin
            ca = ca ^ 8'($urandom_range(1, 255));
        end else if (fault == CK_BAD_B) begin
            cb = cb ^ 8'($urandom_range(1, 255));
        end
        push_byte(ca);
        push_byte(cb);
    endtask

    task automatic push_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input int fault);
        open_frame(cls, id);
        push_summed(len[7:0]);
        push_summed(len[15:8]);
        for (int i = 0; i < int'(len); i++) begin
            push_summed(8'($urandom));
        end
        close_frame(fault);
    endtask

    task automatic push_oversize(input logic [7:0] cls, input logic [7:0] id,
                                 input logic [15:0] len);
        open_frame(cls, id);
        push_summed(len[7:0]);
        push_summed(len[15:8]);
    endtask

    task automatic wait_drain(input int limit);
        int n;
        n = 0;
        while (!is_idle() && n < limit) begin
            @(posedge aclk);
            n++;
        end
        if (!is_idle()) begin
            n_errors++;
            $display("drain stalled: %0d bytes and %0d results outstanding",
                     n_queued - n_accepted, exp_result_q.size());
        end
    endtask

    // Write one register; the tracker copy follows at the handshake
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SYNC_FIRST:  trk_cfg.sync_first  = val[7:0];
            REG_SYNC_SECOND: trk_cfg.sync_second = val[7:0];
            REG_MAX_LEN:     trk_cfg.max_len     = val;
            default: ;
        endcase
        n_reg_writes++;
    endtask

    task automatic write_all(input logic [7:0] s1, input logic [7:0] s2,
                             input logic [15:0] max_len);
        write_reg(REG_SYNC_FIRST, {8'($urandom), s1});
        write_reg(REG_SYNC_SECOND, {8'($urandom), s2});
        write_reg(REG_MAX_LEN, max_len);
    endtask

    // Queue one random sequence; n counts its frame bytes
    task automatic push_random_item(output int n);
        int         k;
        int         cap;
        int         len;
        int         lo;
        int         hi;
        logic [7:0] b;
        k   = $urandom_range(0, 99);
        cap = (trk_cfg.max_len < 24) ? int'(trk_cfg.max_len) : 24;
        n   = 0;
        if (k < 68) begin
            len = $urandom_range(0, cap);
            push_frame(8'($urandom), 8'($urandom), 16'(len), CK_OK);
            n = len + 8;
        end else if (k < 80) begin
            len = $urandom_range(0, cap);
            push_frame(8'($urandom), 8'($urandom), 16'(len),
                       $urandom_range(0, 1) ? CK_BAD_A : CK_BAD_B);
            n = len + 8;
        end else if (k < 87) begin
            b = 8'($urandom);
            if (b == trk_cfg.sync_second) begin
                b = ~b;
            end
            push_byte(trk_cfg.sync_first);
            push_byte(b);
            n = 2;
        end else if (k < 93 && trk_cfg.max_len != 16'hFFFF) begin
            lo = int'(trk_cfg.max_len) + 1;
            hi = (lo + 100 > 65535) ? 65535 : lo + 100;
            len = $urandom_range(0, 3) == 0 ? 65535 : int'($urandom_range(lo, hi));
            push_oversize(8'($urandom), 8'($urandom), 16'(len));
            n = 6;
        end else begin
            // noise, mostly clear of the first sync value
            repeat ($urandom_range(1, 4)) begin
                b = 8'($urandom);
                if (b == trk_cfg.sync_first && $urandom_range(0, 9) != 0) begin
                    b = ~b;
                end
                push_byte(b);
            end
        end
    endtask

    task automatic run_random(input int target);
        int count;
        int n;
        count = 0;
        while (count < target) begin
            push_random_item(n);
            count += n;
        end
        n_rand_bytes += count;
        wait_drain(DRAIN_LIMIT);
    endtask

    // Stimulus
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: noise, bad second sync, discarded sync, zero length,
        // oversize length, checksum error, all under reset defaults
        idle_en = 1'b1;
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SYNC_FIRST_RST);
        push_byte(8'h00);
        push_byte(SYNC_FIRST_RST);
        push_byte(SYNC_FIRST_RST);
        push_byte(SYNC_SECOND_RST);
        push_frame(8'hFF, 8'h00, 16'd0, CK_OK);
        push_oversize(8'h01, 8'h02, 16'h0201);
        push_frame(8'h00, 8'hFF, 16'd1, CK_BAD_B);
        wait_drain(DRAIN_LIMIT);

        // Registers changed with a frame in progress: pause mid-frame each time
        open_frame(8'h0A, 8'h0B);
        wait_drain(DRAIN_LIMIT);
        write_reg(REG_MAX_LEN, 16'd3);
        push_summed(8'd4);
        push_summed(8'd0);
        push_byte(trk_cfg.sync_first);
        wait_drain(DRAIN_LIMIT);
        write_reg(REG_SYNC_SECOND, 16'hA511);
        push_byte(trk_cfg.sync_second);
        start_body(8'h21, 8'h22);
        push_summed(8'd2);
        push_summed(8'd0);
        push_summed(8'($urandom));
        wait_drain(DRAIN_LIMIT);
        write_reg(REG_SYNC_FIRST, 16'h005A);
        push_summed(8'($urandom));
        close_frame(CK_OK);
        push_byte(SYNC_FIRST_RST);
        push_frame(8'h33, 8'h44, 16'd3, CK_OK);
        wait_drain(DRAIN_LIMIT);

        // Extremes: zero sync, all-ones sync, zero length limit
        write_all(8'h00, 8'hFF, 16'd0);
        run_random(120);

        // Swapped extremes with no idling on either side
        idle_en = 1'b0;
        write_all(8'hFF, 8'h00, 16'd24);
        run_random(150);
        idle_en = 1'b1;

        // Both sync values equal
        begin
            logic [7:0] s;
            s = 8'($urandom);
            write_all(s, s, 16'($urandom_range(1, 30)));
        end
        run_random(150);

        // Fully random setting
        write_all(8'($urandom), 8'($urandom), 16'($urandom_range(0, 40)));
        run_random(200);

        // Largest limit, then random traffic
        write_all(SYNC_FIRST_RST, SYNC_SECOND_RST, 16'hFFFF);
        run_random(100);

        repeat (16) @(posedge aclk);

        $display("Ran %0d bytes (%0d in random frames) over %0d register writes.",
                 n_accepted, n_rand_bytes, n_reg_writes);
        $display("Saw %0d good frames, %0d checksum errors, %0d drops; %0d errors.",
                 trk_good_cnt, trk_err_cnt, n_drops, n_errors);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== gnss_binary_frame_parser_core.f =====
hdl/gfp_pkg.sv
hdl/gfp_parse.sv
hdl/gfp_out_buf.sv
hdl/gnss_binary_frame_parser_core.sv
test/tb_gnss_binary_frame_parser_core.sv
